[hdl/bcf_pkg.sv]
// ----------------------------------------------------------------------------
// Bezier curve flattener package
// Shared types and constants for the flattener front end and subdivider.
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int COORD_W = 32;
    localparam int ERR_W   = 38;
    localparam int LVL_W   = 3;

    localparam logic OP_QUAD  = 1'b0;
    localparam logic OP_CUBIC = 1'b1;

    localparam logic [1:0] REG_FLAT_TOL = 2'd0;
    localparam logic [31:0] FLAT_TOL_RESET = 32'sd65536;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // One curve as handed from the front end to the subdivider.
    typedef struct packed {
        logic   cubic;
        t_point p0;
        t_point p1;
        t_point p2;
        t_point p3;
    } t_curve;

    // floor((a + b) / 2) at 33 bits.
    function automatic t_coord half_sum(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    // |a + c - 2b| at full width.
    function automatic logic [ERR_W-1:0] abs_d2(input t_coord a, input t_coord b,
                                                input t_coord c);
        logic signed [COORD_W+2:0] d;
        d = (COORD_W+3)'(a) + (COORD_W+3)'(c) - ((COORD_W+3)'(b) <<< 1);
        return d[COORD_W+2] ? ERR_W'(-d) : ERR_W'(d);
    endfunction

endpackage

[hdl/bcf_if.sv]
// ----------------------------------------------------------------------------
// Flattener stream interfaces
// Valid/ready channels for curves in and polyline points out.
// ----------------------------------------------------------------------------
interface bcf_curve_if;
    logic op;
    logic signed [31:0] x0, y0, x1, y1, x2, y2, x3, y3;
    logic valid;
    logic ready;
    modport source (output op, x0, y0, x1, y1, x2, y2, x3, y3, valid, input ready);
    modport sink   (input op, x0, y0, x1, y1, x2, y2, x3, y3, valid, output ready);
endinterface

interface bcf_point_if;
    logic signed [31:0] point_x, point_y;
    logic last;
    logic valid;
    logic ready;
    modport source (output point_x, point_y, last, valid, input ready);
    modport sink   (input point_x, point_y, last, valid, output ready);
endinterface

[hdl/bcf_front.sv]
// ----------------------------------------------------------------------------
// Flattener front end
// Accepts curve beats and queues them in a two-entry FIFO for the subdivider.
// ----------------------------------------------------------------------------
module bcf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bcf_curve_if.sink       s_in,
    output bcf_pkg::t_curve o_curve,
    output logic            o_valid,
    input  logic            i_take
);
    import bcf_pkg::*;

    t_curve     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_curve     w_in;
    logic       w_push, w_pop;

    // Classify the beat and unpack its points; a quadratic leaves slot three unused.
    always_comb begin
        w_in.cubic = (s_in.op == OP_CUBIC);
        w_in.p0 = '{s_in.x0, s_in.y0};
        w_in.p1 = '{s_in.x1, s_in.y1};
        w_in.p2 = '{s_in.x2, s_in.y2};
        w_in.p3 = '{s_in.x3, s_in.y3};
    end

    assign s_in.ready = (r_cnt != 2'd2);
    assign w_push     = s_in.valid && s_in.ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign w_pop      = o_valid && i_take;
    assign o_curve    = r_mem[r_rp];

    // Hold queued curves.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_in;
        end
    end

    // Advance pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

[hdl/bcf_subdiv.sv]
// ----------------------------------------------------------------------------
// Flattener subdivider
// Depth-first de Casteljau subdivision, one segment per cycle unless a flat segment
// waits for the output slot, with a stack of pending right halves and a registered output point.
// ----------------------------------------------------------------------------
module bcf_subdiv #(
    parameter int MAX_DEPTH = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bcf_pkg::t_curve i_curve,
    input  logic            i_valid,
    output logic            o_take,
    input  logic [31:0]     i_tol,
    bcf_point_if.source     m_out
);
    import bcf_pkg::*;

    localparam int SP_W = $clog2(MAX_DEPTH + 1);
    localparam int IX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_STEP  = 4'b0100,
        S_END   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic            r_cubic;
    t_point          r_seg [4];
    logic [LVL_W-1:0] r_lvl;
    logic [SP_W-1:0] r_sp;
    t_point          r_stk [MAX_DEPTH][4];
    logic [LVL_W-1:0] r_stk_lvl [MAX_DEPTH];
    logic            r_ov;
    t_point          r_opt;
    logic            r_olast;

    t_point q1x [4];  // row 1
    t_point q2x [4];  // row 2
    t_point q3x;      // row 3
    t_point w_mid;
    t_point w_left [4];
    t_point w_right [4];
    logic [ERR_W-1:0] w_err;
    logic            w_flat, w_oslot;
    logic [IX_W-1:0] w_top;

    assign w_oslot = !r_ov || m_out.ready;
    assign w_top   = IX_W'(r_sp - SP_W'(1));

    // Split the current segment at t = 1/2.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q1x[i].x = half_sum(r_seg[i].x, r_seg[i+1].x);
            q1x[i].y = half_sum(r_seg[i].y, r_seg[i+1].y);
        end
        q1x[3] = r_seg[3];
        for (int i = 0; i < 2; i++) begin
            q2x[i].x = half_sum(q1x[i].x, q1x[i+1].x);
            q2x[i].y = half_sum(q1x[i].y, q1x[i+1].y);
        end
        q2x[2] = r_seg[2];
        q2x[3] = r_seg[3];
        q3x.x = half_sum(q2x[0].x, q2x[1].x);
        q3x.y = half_sum(q2x[0].y, q2x[1].y);
        if (r_cubic) begin
            w_mid      = q3x;
            w_left     = '{r_seg[0], q1x[0], q2x[0], q3x};
            w_right    = '{q3x, q2x[1], q1x[2], r_seg[3]};
            w_err = abs_d2(r_seg[0].x, r_seg[1].x, r_seg[2].x)
                  + abs_d2(r_seg[0].y, r_seg[1].y, r_seg[2].y)
                  + abs_d2(r_seg[1].x, r_seg[2].x, r_seg[3].x)
                  + abs_d2(r_seg[1].y, r_seg[2].y, r_seg[3].y);
        end else begin
            w_mid      = q2x[0];
            w_left     = '{r_seg[0], q1x[0], q2x[0], r_seg[3]};
            w_right    = '{q2x[0], q1x[1], r_seg[2], r_seg[3]};
            w_err = abs_d2(r_seg[0].x, r_seg[1].x, r_seg[2].x)
                  + abs_d2(r_seg[0].y, r_seg[1].y, r_seg[2].y);
        end
        w_flat = (r_lvl >= LVL_W'(MAX_DEPTH))
              || ($signed({1'b0, w_err}) <= $signed((ERR_W+1)'($signed(i_tol))));
    end

    // Sequence start point, subdivision steps and end point.
    always_comb begin
        n_state = r_state;
        o_take  = 1'b0;
        unique case (r_state)
            S_IDLE:  if (i_valid && w_oslot) begin
                o_take  = 1'b1;
                n_state = S_STEP;
            end
            S_START: n_state = S_STEP;
            S_STEP:  if (w_oslot && w_flat && r_sp == '0) n_state = S_END;
            S_END:   if (w_oslot) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_sp    <= '0;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            if (m_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_take) begin
                    r_ov    <= 1'b1;
                    r_sp    <= '0;
                    r_lvl   <= '0;
                end
                S_STEP: if (w_oslot) begin
                    if (!w_flat) begin
                        r_lvl <= r_lvl + LVL_W'(1);
                        if (r_sp < SP_W'(MAX_DEPTH)) r_sp <= r_sp + SP_W'(1);
                    end else begin
                        r_ov <= 1'b1;
                        if (r_sp != '0) begin
                            r_sp  <= r_sp - SP_W'(1);
                            r_lvl <= r_stk_lvl[w_top];
                        end
                    end
                end else if (!w_flat) begin
                    r_lvl <= r_lvl + LVL_W'(1);
                    if (r_sp < SP_W'(MAX_DEPTH)) r_sp <= r_sp + SP_W'(1);
                end
                S_END: if (w_oslot) r_ov <= 1'b1;
                default: ;
            endcase
        end
    end

    // Segment, stack and output payload.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (o_take) begin
                r_cubic <= i_curve.cubic;
                r_seg   <= '{i_curve.p0, i_curve.p1, i_curve.p2, i_curve.p3};
                r_opt   <= i_curve.p0;
                r_olast <= 1'b0;
            end
            S_STEP: if (!w_flat) begin
                r_seg <= w_left;
                if (r_sp < SP_W'(MAX_DEPTH)) begin
                    r_stk[IX_W'(r_sp)]     <= w_right;
                    r_stk_lvl[IX_W'(r_sp)] <= r_lvl + LVL_W'(1);
                end
            end else if (w_oslot) begin
                r_opt   <= w_mid;
                r_olast <= 1'b0;
                if (r_sp != '0) r_seg <= r_stk[w_top];
            end
            S_END: if (w_oslot) begin
                r_opt   <= r_cubic ? r_seg[3] : r_seg[2];
                r_olast <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_out.valid   = r_ov;
    assign m_out.point_x = r_opt.x;
    assign m_out.point_y = r_opt.y;
    assign m_out.last    = r_olast;

endmodule

[hdl/bezier_curve_flattener.sv]
// ----------------------------------------------------------------------------
// Bezier curve flattener
// Adaptive de Casteljau flattening of quadratic and cubic curves.
// ----------------------------------------------------------------------------
// The first point (start) is registered as a curve leaves the input queue and
// is valid in the next cycle. The subdivider makes one subdivision step per
// cycle unless a flat segment waits for the output point to be taken.
// A two-entry queue takes the next curves while one is being flattened.
// Reset (synchronous, active low) empties the queue and restores tolerance 1.0.
module bezier_curve_flattener #(
    parameter int MAX_DEPTH = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcf_curve_if.sink   s_in,
    bcf_point_if.source m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bcf_pkg::*;

    logic [31:0] r_tol;
    t_curve      w_curve;
    logic        w_valid, w_take;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_FLAT_TOL) ? r_tol : 32'd0;

    // Write the tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= FLAT_TOL_RESET;
        end else if (psel && penable && pwrite && paddr == REG_FLAT_TOL) begin
            r_tol <= pwdata;
        end
    end

    bcf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .o_curve (w_curve),
        .o_valid (w_valid),
        .i_take  (w_take)
    );

    bcf_subdiv #(.MAX_DEPTH(MAX_DEPTH)) u_subdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_curve (w_curve),
        .i_valid (w_valid),
        .o_take  (w_take),
        .i_tol   (r_tol),
        .m_out   (m_out)
    );

endmodule
